@@ rtl/iitl_pkg.sv @@
// ----------------------------------------------------------------------------
// iitl_pkg
// shared types, constants and register codes of the indirect index lane
// ----------------------------------------------------------------------------
package iitl_pkg;

  localparam int unsigned LineBytes  = 64;
  localparam int unsigned SeenDepth  = 64;
  localparam int unsigned LineLg     = $clog2(LineBytes);
  localparam int unsigned KeyW       = 64 - LineLg;
  localparam int unsigned SeenIdxW   = $clog2(SeenDepth);
  localparam int unsigned SeenCntW   = $clog2(SeenDepth + 1);
  localparam logic [63:0] TopMask    = 64'hffffff0000000000;

  // register indexes of the configuration port
  localparam logic [2:0] RegFormBase    = 3'd0;
  localparam logic [2:0] RegFormShift   = 3'd1;
  localparam logic [2:0] RegExtBits     = 3'd2;
  localparam logic [2:0] RegExtSigned   = 3'd3;
  localparam logic [2:0] RegElemBytes   = 3'd4;
  localparam logic [2:0] RegPreLaneDup  = 3'd5;
  localparam logic [2:0] RegWindowDup   = 3'd6;
  localparam logic [2:0] RegWindowShift = 3'd7;

  typedef enum logic [1:0] {
    OUT_EMIT      = 2'd0,
    OUT_PRE_DUP   = 2'd1,
    OUT_FILTERED  = 2'd2,
    OUT_POST_DUP  = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [63:0] form_base;
    logic [5:0]  form_shift;
    logic [6:0]  ext_bits;
    logic        ext_signed;
    logic [3:0]  elem_bytes;
    logic        early_dedup;
    logic        window_dedup;
    logic [5:0]  window_shift;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [63:0] scaled;
    logic [63:0] vaddr;
    logic        start;
    logic        bad;
  } item_t;

endpackage

@@ rtl/iitl_ram.sv @@
// ----------------------------------------------------------------------------
// iitl_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module iitl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/iitl_front.sv @@
// ----------------------------------------------------------------------------
// iitl_front
// masks, extends and shifts the raw index element and flags a bad width
// ----------------------------------------------------------------------------
module iitl_front (
  input  iitl_pkg::cfg_t  cfg_i,
  input  logic [63:0]     raw_i,
  input  logic [63:0]     vaddr_i,
  input  logic            start_i,
  output iitl_pkg::item_t item_o
);

  logic [63:0] masked;
  logic [63:0] emask;
  logic [63:0] extended;
  logic        ext_on;
  logic        sbit;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (cfg_i.elem_bytes > 4'(i)) ? raw_i[8*i +: 8] : 8'h00;
    end
  end

  assign ext_on = !cfg_i.ext_bits[6] && (cfg_i.ext_bits[5:0] != 6'd0);
  assign emask  = ~({64{1'b1}} << cfg_i.ext_bits[5:0]);
  assign sbit   = masked[cfg_i.ext_bits[5:0] - 6'd1];

  always_comb begin
    extended = masked;
    if (ext_on) begin
      extended = (masked & emask) | ((cfg_i.ext_signed && sbit) ? ~emask : 64'd0);
    end
  end

  assign item_o.scaled = extended << cfg_i.form_shift;
  assign item_o.vaddr  = vaddr_i;
  assign item_o.start  = start_i;
  assign item_o.bad    = (cfg_i.elem_bytes == 4'd0) || (cfg_i.elem_bytes > 4'd8);

endmodule

@@ rtl/iitl_queue.sv @@
// ----------------------------------------------------------------------------
// iitl_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module iitl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  iitl_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output iitl_pkg::item_t item_o
);

  iitl_pkg::item_t slot_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = slot_q[rptr_q];

endmodule

@@ rtl/iitl_back.sv @@
// ----------------------------------------------------------------------------
// iitl_back
// forms the target, keeps the seen-set and produces one result per item
// ----------------------------------------------------------------------------
module iitl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iitl_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  iitl_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [63:0]     res_target_o,
  output logic [1:0]      res_outcome_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                              state_q, state_d;
  logic [63:0]                       target_q, target_d;
  logic [iitl_pkg::KeyW-1:0]         key_q, key_d;
  logic [iitl_pkg::SeenCntW-1:0]     count_q, count_d;
  logic [iitl_pkg::SeenCntW-1:0]     idx_q, idx_d;
  logic                              pend_q, pend_d;
  logic                              hit_q, hit_d;
  logic [63:0]                       wkey_q, wkey_d;
  logic                              rvalid_q, rvalid_d;
  logic [63:0]                       rtarget_q, rtarget_d;
  iitl_pkg::outcome_e                routc_q, routc_d;

  logic                              out_free;
  logic [63:0]                       tgt_sum, low_sum, wk;
  logic                              filt;
  logic                              ram_we;
  logic [iitl_pkg::KeyW-1:0]         rdata;

  assign out_free = !rvalid_q || res_ready_i;
  assign tgt_sum  = cfg_i.form_base + q_item_i.scaled;
  assign low_sum  = q_item_i.scaled
                  + {{(64-iitl_pkg::LineLg){1'b0}}, cfg_i.form_base[iitl_pkg::LineLg-1:0]};
  assign wk       = q_item_i.vaddr >> cfg_i.window_shift;
  assign filt     = (target_q == 64'd0) || ((target_q & iitl_pkg::TopMask) != 64'd0);

  iitl_ram #(
    .Width (iitl_pkg::KeyW),
    .Depth (iitl_pkg::SeenDepth)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[iitl_pkg::SeenIdxW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[iitl_pkg::SeenIdxW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    target_d  = target_q;
    key_d     = key_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    hit_d     = hit_q;
    wkey_d    = wkey_q;
    rvalid_d  = rvalid_q && !res_ready_i;
    rtarget_d = rtarget_q;
    routc_d   = routc_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_item_i.bad) begin
            rvalid_d  = 1'b1;
            rtarget_d = 64'd0;
            routc_d   = iitl_pkg::OUT_FILTERED;
          end else begin
            if (cfg_i.window_dedup) begin
              if (wk != wkey_q) begin
                wkey_d  = wk;
                count_d = '0;
              end
            end else if (q_item_i.start) begin
              count_d = '0;
            end
            target_d = tgt_sum;
            key_d    = cfg_i.early_dedup ? low_sum[63:iitl_pkg::LineLg]
                                         : tgt_sum[63:iitl_pkg::LineLg];
            idx_d    = '0;
            hit_d    = 1'b0;
            state_d  = StScan;
          end
        end
      end
      StScan: begin
        if (!cfg_i.early_dedup && filt) begin
          rvalid_d  = 1'b1;
          rtarget_d = 64'd0;
          routc_d   = iitl_pkg::OUT_FILTERED;
          state_d   = StIdle;
        end else if (!pend_q && (idx_q == count_q)) begin
          // scan finished
          rvalid_d = 1'b1;
          state_d  = StIdle;
          if (hit_q) begin
            rtarget_d = 64'd0;
            if (cfg_i.early_dedup) begin
              routc_d = iitl_pkg::OUT_PRE_DUP;
            end else begin
              routc_d = iitl_pkg::OUT_POST_DUP;
            end
          end else if (filt) begin
            rtarget_d = 64'd0;
            routc_d   = iitl_pkg::OUT_FILTERED;
          end else begin
            rtarget_d = target_q;
            routc_d   = iitl_pkg::OUT_EMIT;
            if (count_q < iitl_pkg::SeenCntW'(iitl_pkg::SeenDepth)) begin
              ram_we  = 1'b1;
              count_d = count_q + iitl_pkg::SeenCntW'(1);
            end
          end
        end else begin
          if (pend_q && (rdata == key_q)) begin
            hit_d = 1'b1;
          end
          if (idx_q != count_q) begin
            idx_d  = idx_q + iitl_pkg::SeenCntW'(1);
            pend_d = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    key_q     <= key_d;
    rtarget_q <= rtarget_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      wkey_q   <= 64'd0;
      rvalid_q <= 1'b0;
      routc_q  <= iitl_pkg::OUT_EMIT;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      wkey_q   <= wkey_d;
      rvalid_q <= rvalid_d;
      routc_q  <= routc_d;
    end
  end

  assign res_valid_o   = rvalid_q;
  assign res_target_o  = rtarget_q;
  assign res_outcome_o = routc_q;

endmodule

@@ rtl/indirect_index_to_target_lane.sv @@
// ----------------------------------------------------------------------------
// indirect_index_to_target_lane
// turns index elements into deduplicated prefetch target addresses
// ----------------------------------------------------------------------------
// Each accepted element gives exactly one result transaction: a target and an
// outcome code (emitted, pre-lane duplicate, filtered, post-lane duplicate).
// Elements enter a two-entry queue after masking, extension and shifting, so
// input is taken while the back end works. The back end handles one element
// at a time and takes the next one only once the previous result has left:
// an element with a bad width is answered from the idle state, a post-lane
// filtered element is answered without a scan, and any other element scans
// the n keys held (0 to 64) one by one, since the set lives in a ram with
// one registered read port scanned one key per cycle. The seen-set needs no
// clearing pass after reset.
module indirect_index_to_target_lane (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // raw_element, element_vaddr
  input  logic         s_axis_tuser,  // line_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // target_address
  output logic [1:0]   m_axis_tuser   // outcome
);

  iitl_pkg::cfg_t  cfg_q;
  iitl_pkg::item_t front_item, q_item;
  logic            q_full, q_valid, q_pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.form_base      <= 64'd0;
      cfg_q.form_shift     <= 6'd0;
      cfg_q.ext_bits       <= 7'd0;
      cfg_q.ext_signed     <= 1'b0;
      cfg_q.elem_bytes     <= 4'd4;
      cfg_q.early_dedup    <= 1'b0;
      cfg_q.window_dedup   <= 1'b0;
      cfg_q.window_shift   <= 6'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iitl_pkg::RegFormBase:    cfg_q.form_base      <= cfg_wdata_i;
        iitl_pkg::RegFormShift:   cfg_q.form_shift     <= cfg_wdata_i[5:0];
        iitl_pkg::RegExtBits:     cfg_q.ext_bits       <= cfg_wdata_i[6:0];
        iitl_pkg::RegExtSigned:   cfg_q.ext_signed     <= cfg_wdata_i[0];
        iitl_pkg::RegElemBytes:   cfg_q.elem_bytes     <= cfg_wdata_i[3:0];
        iitl_pkg::RegPreLaneDup:  cfg_q.early_dedup    <= cfg_wdata_i[0];
        iitl_pkg::RegWindowDup:   cfg_q.window_dedup   <= cfg_wdata_i[0];
        iitl_pkg::RegWindowShift: cfg_q.window_shift   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  iitl_front u_front (
    .cfg_i   (cfg_q),
    .raw_i   (s_axis_tdata[63:0]),
    .vaddr_i (s_axis_tdata[127:64]),
    .start_i (s_axis_tuser),
    .item_o  (front_item)
  );

  iitl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  iitl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_target_o  (m_axis_tdata),
    .res_outcome_o (m_axis_tuser)
  );

endmodule

@@ bench/indirect_index_to_target_lane_tb.sv @@
// ----------------------------------------------------------------------------
// indirect_index_to_target_lane_tb
// self-checking bench for the index element to prefetch target lane
// ----------------------------------------------------------------------------
// Index elements are streamed in as short directed cases, then as random
// phases of cache-line shaped runs, long runs that fill the seen-set, and
// noise. Each phase programs new register settings while the lane is idle and
// picks its own mix of sender gaps and receiver stalls; one phase holds the
// receiver off long enough to back the lane up. A scoreboard class keeps its
// own copy of the registers and the seen-set, predicts target and outcome for
// every accepted element and compares them with each result transaction.
module indirect_index_to_target_lane_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 102;

  typedef struct {
    logic [63:0]          target;
    iitl_pkg::outcome_e   outcome;
  } lane_result_t;

  class target_checker;
    iitl_pkg::cfg_t            cfg;
    logic [iitl_pkg::KeyW-1:0] seen_keys [iitl_pkg::SeenDepth];
    int unsigned               seen_n;
    logic [63:0]               window_key;
    lane_result_t              expected_targets [$];
    int unsigned               errors;

    function new();
      cfg            = '0;
      cfg.elem_bytes = 4'd4;
      cfg.window_shift = 6'd6;
      seen_n     = 0;
      window_key = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        iitl_pkg::RegFormBase:    cfg.form_base      = v;
        iitl_pkg::RegFormShift:   cfg.form_shift     = v[5:0];
        iitl_pkg::RegExtBits:     cfg.ext_bits       = v[6:0];
        iitl_pkg::RegExtSigned:   cfg.ext_signed     = v[0];
        iitl_pkg::RegElemBytes:   cfg.elem_bytes     = v[3:0];
        iitl_pkg::RegPreLaneDup:  cfg.early_dedup    = v[0];
        iitl_pkg::RegWindowDup:   cfg.window_dedup   = v[0];
        iitl_pkg::RegWindowShift: cfg.window_shift   = v[5:0];
        default: ;
      endcase
    endfunction

    function bit seen_has(logic [iitl_pkg::KeyW-1:0] k);
      for (int unsigned i = 0; i < seen_n; i++) begin
        if (seen_keys[i] == k) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void expect_result(lane_result_t r);
      expected_targets.insert(expected_targets.size(), r);
    endfunction

    function void note_element(logic [63:0] raw, logic [63:0] vaddr, logic start);
      lane_result_t              r;
      logic [63:0]               el;
      logic [63:0]               m;
      logic [63:0]               scaled;
      logic [63:0]               target;
      logic [63:0]               sum;
      logic [iitl_pkg::KeyW-1:0] key;
      r.target  = '0;
      r.outcome = iitl_pkg::OUT_FILTERED;
      if (cfg.elem_bytes == 0 || cfg.elem_bytes > 8) begin
        expect_result(r);
        return;
      end
      if (cfg.window_dedup) begin
        if ((vaddr >> cfg.window_shift) != window_key) begin
          window_key = vaddr >> cfg.window_shift;
          seen_n     = 0;
        end
      end else if (start) begin
        seen_n = 0;
      end
      el = raw;
      if (cfg.elem_bytes < 8) el = raw & ((64'd1 << (8 * cfg.elem_bytes)) - 64'd1);
      if (cfg.ext_bits > 0 && cfg.ext_bits < 64) begin
        m  = (64'd1 << cfg.ext_bits) - 64'd1;
        el = el & m;
        if (cfg.ext_signed && el[cfg.ext_bits - 1]) el = el | ~m;
      end
      scaled = el << cfg.form_shift;
      target = cfg.form_base + scaled;
      key    = '0;
      if (cfg.early_dedup) begin
        sum = scaled + (cfg.form_base & 64'(iitl_pkg::LineBytes - 1));
        key = sum[63:iitl_pkg::LineLg];
        if (seen_has(key)) begin
          r.outcome = iitl_pkg::OUT_PRE_DUP;
          expect_result(r);
          return;
        end
      end
      if (target == 64'd0 || (target & iitl_pkg::TopMask) != 64'd0) begin
        expect_result(r);
        return;
      end
      if (!cfg.early_dedup) begin
        key = target[63:iitl_pkg::LineLg];
        if (seen_has(key)) begin
          r.outcome = iitl_pkg::OUT_POST_DUP;
          expect_result(r);
          return;
        end
      end
      // a full set keeps its keys and drops the new one
      if (seen_n < iitl_pkg::SeenDepth) begin
        seen_keys[seen_n] = key;
        seen_n++;
      end
      r.target  = target;
      r.outcome = iitl_pkg::OUT_EMIT;
      expect_result(r);
    endfunction

    function void check_target(logic [63:0] t, logic [1:0] o);
      lane_result_t e;
      if (expected_targets.size() == 0) begin
        $display("%0t: result with no element pending: target %h outcome %0d", $time, t, o);
        errors++;
        return;
      end
      e = expected_targets[0];
      expected_targets.delete(0);
      if (t !== e.target) begin
        $display("%0t: target mismatch: expected %h, actual %h", $time, e.target, t);
        errors++;
      end
      if (o !== e.outcome) begin
        $display("%0t: outcome mismatch: expected %0d, actual %0d", $time, e.outcome, o);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_targets.size();
    endfunction
  endclass

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         cfg_we    = 1'b0;
  logic [2:0]   cfg_idx   = '0;
  logic [63:0]  cfg_wdata = '0;
  logic         s_valid   = 1'b0;
  logic [127:0] s_data    = '0;
  logic         s_user    = 1'b0;
  logic         m_ready   = 1'b0;
  logic         s_ready;
  logic         m_valid;
  logic [63:0]  m_data;
  logic [1:0]   m_user;

  target_checker sb;
  int unsigned   src_idle_pct = 0;
  int unsigned   snk_stall_pct = 0;
  bit            hold_req = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;
  logic [63:0]   raw_pool [8];

  indirect_index_to_target_lane u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // input and result transactions
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready) sb.note_element(s_data[63:0], s_data[127:64], s_user);
    if (rst_n && m_valid && m_ready) sb.check_target(m_data, m_user);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("indirect_index_to_target_lane test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic set_idle(input int unsigned mode);
    case (mode)
      1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
      3: begin src_idle_pct = 17; snk_stall_pct = 17; end
      default: begin src_idle_pct = 0; snk_stall_pct = 0; end
    endcase
  endtask

  task automatic send_elem(input logic [63:0] raw, input logic [63:0] vaddr,
                           input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {vaddr, raw};
    s_user  <= start;
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] field,
                           input int unsigned w);
    logic [63:0] junk;
    logic [63:0] v;
    junk = {$urandom, $urandom};
    v    = (junk & ~((64'd1 << w) - 64'd1)) | field;
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic apply_config(input iitl_pkg::cfg_t c);
    wait_idle();
    write_reg(iitl_pkg::RegFormBase,    c.form_base,           64);
    write_reg(iitl_pkg::RegFormShift,   64'(c.form_shift),     6);
    write_reg(iitl_pkg::RegExtBits,     64'(c.ext_bits),       7);
    write_reg(iitl_pkg::RegExtSigned,   64'(c.ext_signed),     1);
    write_reg(iitl_pkg::RegElemBytes,   64'(c.elem_bytes),     4);
    write_reg(iitl_pkg::RegPreLaneDup,  64'(c.early_dedup),    1);
    write_reg(iitl_pkg::RegWindowDup,   64'(c.window_dedup),   1);
    write_reg(iitl_pkg::RegWindowShift, 64'(c.window_shift),   6);
    cfg_we <= 1'b0;
  endtask

  function automatic iitl_pkg::cfg_t pick_config(input int unsigned n);
    iitl_pkg::cfg_t c;
    int unsigned    r;
    r = $urandom_range(9);
    if (r == 0)      c.form_base = '0;
    else if (r == 1) c.form_base = '1;
    else             c.form_base = {24'h0, 40'({$urandom, $urandom})};
    r = $urandom_range(9);
    if (r == 0)      c.form_shift = 6'd0;
    else if (r == 1) c.form_shift = 6'd63;
    else             c.form_shift = 6'($urandom_range(12));
    case ($urandom_range(9))
      0: c.ext_bits = 7'd0;
      1: c.ext_bits = 7'd64;
      2: c.ext_bits = 7'd127;
      3: c.ext_bits = 7'd1;
      4: c.ext_bits = 7'd63;
      5: c.ext_bits = 7'($urandom_range(126, 65));
      default: c.ext_bits = 7'($urandom_range(40, 2));
    endcase
    c.ext_signed = 1'($urandom_range(1));
    if ($urandom_range(11) == 0) c.elem_bytes = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
    else                         c.elem_bytes = 4'($urandom_range(8, 1));
    c.early_dedup  = 1'($urandom_range(1));
    c.window_dedup = 1'($urandom_range(1));
    r = $urandom_range(9);
    if (r == 0)      c.window_shift = 6'd0;
    else if (r == 1) c.window_shift = 6'd63;
    else if (r == 2) c.window_shift = 6'($urandom_range(5, 1));
    else             c.window_shift = 6'($urandom_range(16, 6));
    case (n)
      0: begin
        c.form_base = '0; c.form_shift = '0; c.ext_bits = '0; c.elem_bytes = 4'd1;
        c.window_dedup = 1'b0;
      end
      1: begin
        c.form_base = '1; c.form_shift = '0; c.ext_bits = '0; c.elem_bytes = 4'd1;
      end
      2: begin
        c.form_base = 64'h1000; c.form_shift = '0; c.ext_bits = '0; c.elem_bytes = 4'd4;
        c.window_dedup = 1'b1; c.window_shift = 6'd63;
      end
      3: c.elem_bytes = 4'd15;
      5: begin
        c.form_base = '1; c.form_shift = 6'd63; c.ext_bits = 7'd127; c.elem_bytes = 4'd8;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] pick_raw(input int unsigned fresh_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < fresh_pct) return {$urandom, $urandom};
    return raw_pool[$urandom_range(7)] ^ 64'($urandom_range(3));
  endfunction

  task automatic run_phase(input int unsigned n);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned fresh;
    int unsigned step;
    logic [63:0] va;
    sent = 0;
    foreach (raw_pool[i]) raw_pool[i] = {$urandom, $urandom};
    apply_config(pick_config(n));
    set_idle((n == 4) ? 0 : n % 4);
    if (n == 4) hold_req = 1'b1;
    step = (sb.cfg.elem_bytes >= 1 && sb.cfg.elem_bytes <= 8) ? sb.cfg.elem_bytes : 8;
    while (sent < PhaseItems) begin
      kind = (n == 2 && sent == 0) ? 70 : $urandom_range(99);
      va   = {$urandom, $urandom} & ~64'(iitl_pkg::LineBytes - 1);
      if (kind < 65) begin
        len   = iitl_pkg::LineBytes / step;
        fresh = 30;
      end else if (kind < 85) begin
        len   = $urandom_range(150, 90);
        fresh = 90;
      end else begin
        len   = $urandom_range(6, 1);
        fresh = 100;
      end
      for (int unsigned k = 0; k < len && sent < PhaseItems; k++) begin
        if (kind < 85) send_elem(pick_raw(fresh), va + 64'(k * step), k == 0);
        else send_elem({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    iitl_pkg::cfg_t c;
    sb = new();
    set_idle(3);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero target, masking, duplicate line, line start
    send_elem(64'h0, 64'h1000, 1'b1);
    send_elem(64'h40, 64'h1004, 1'b0);
    send_elem(64'h7f, 64'h1008, 1'b0);
    send_elem('1, 64'h100c, 1'b0);
    send_elem(64'h40, 64'h1040, 1'b1);

    // sign extension of a negative index
    c = sb.cfg;
    c.elem_bytes = 4'd8; c.form_base = 64'h1000; c.ext_bits = 7'd8; c.ext_signed = 1'b1;
    apply_config(c);
    send_elem(64'h80, 64'h2000, 1'b1);
    send_elem('1, 64'h2008, 1'b0);

    // top bits of the target
    c.ext_bits = 7'd0; c.ext_signed = 1'b0; c.form_base = '0;
    apply_config(c);
    send_elem('1, 64'h3000, 1'b1);
    send_elem(64'h0000_00ff_ffff_ffff, 64'h3008, 1'b0);
    send_elem(64'h0000_0100_0000_0000, 64'h3010, 1'b0);

    // pre-lane key duplicate
    c.early_dedup = 1'b1; c.elem_bytes = 4'd2; c.form_shift = 6'd6; c.form_base = 64'h3f;
    apply_config(c);
    send_elem(64'h5, 64'h4000, 1'b1);
    send_elem(64'h5, 64'h4002, 1'b0);
    send_elem(64'h6, 64'h4004, 1'b0);

    // bad element widths leave the state alone
    c.elem_bytes = 4'd0;
    apply_config(c);
    send_elem(64'h5, 64'h4006, 1'b0);
    c.elem_bytes = 4'd15; c.form_shift = 6'd63; c.form_base = '1; c.ext_bits = 7'd127;
    apply_config(c);
    send_elem('1, '1, 1'b1);

    // window mode with a window below the line size
    c = '0;
    c.elem_bytes = 4'd1; c.form_base = 64'h40; c.form_shift = 6'd6;
    c.window_dedup = 1'b1; c.window_shift = 6'd0;
    apply_config(c);
    send_elem(64'h1, 64'h10, 1'b0);
    send_elem(64'h1, 64'h10, 1'b1);
    send_elem(64'h1, 64'h11, 1'b0);

    for (int unsigned n = 0; n < NumPhases; n++) run_phase(n);

    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("indirect_index_to_target_lane test passed");
    end else begin
      $display("indirect_index_to_target_lane test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/iitl_pkg.sv
rtl/iitl_ram.sv
rtl/iitl_front.sv
rtl/iitl_queue.sv
rtl/iitl_back.sv
rtl/indirect_index_to_target_lane.sv
bench/indirect_index_to_target_lane_tb.sv
